// File: src/string_literal_escape_decoder_defines.svh
// ----------------------------------------------------------------------------
// String literal escape decoder assertion macros
// Concurrent assertion wrappers on the top-level clock and reset.
// ----------------------------------------------------------------------------
`ifndef STRING_LITERAL_ESCAPE_DECODER_DEFINES_SVH
`define STRING_LITERAL_ESCAPE_DECODER_DEFINES_SVH

// Check outside reset only.
`define SLED_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define SLED_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/sled_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String literal escape decoder package
// Result kinds, character codes, table request and result types.
// ----------------------------------------------------------------------------
package sled_pkg;

    localparam int TBL_DEPTH = 256;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int MAX_RES   = 3;
    localparam int CNT_W     = 2;

    localparam logic       REG_IDX_RADIX = 1'b0;
    localparam logic [3:0] RADIX_RESET   = 4'd10;
    localparam logic [3:0] RADIX_OCT     = 4'd8;

    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] CODE_LF    = 8'h0A;
    localparam logic [7:0] CODE_TAB   = 8'h09;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_QUOTE = 8'h22;

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_NONOCT = 3'd1,
        KIND_OCTEND = 3'd2,
        KIND_UNTERM = 3'd3,
        KIND_CLOSED = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

    typedef struct packed {
        logic              wr_en;
        logic [TBL_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [TBL_AW-1:0] rd_addr;
    } t_tbl_req;

endpackage

// File: src/sled_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String literal escape decoder channels
// Valid/ready interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface sled_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] char_byte;
    logic       end_of_text;
    logic [7:0] table_index;
    logic [7:0] table_value;

    modport source (output valid, req_type, char_byte, end_of_text, table_index,
                    table_value, input ready);
    modport sink (input valid, req_type, char_byte, end_of_text, table_index,
                  table_value, output ready);
endinterface

interface sled_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] result_kind;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, result_kind, out_byte, last_of_run, input ready);
    modport sink (input valid, result_kind, out_byte, last_of_run, output ready);
endinterface

// File: src/sled_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Translation table
// 256 x 8 memory with per-entry valid bits; unwritten entries read as index.
// ----------------------------------------------------------------------------
module sled_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sled_pkg::t_tbl_req i_req,
    output logic [7:0]         o_rd_data
);

    logic [7:0]                     r_mem [sled_pkg::TBL_DEPTH];
    logic [sled_pkg::TBL_DEPTH-1:0] r_vld;
    logic [7:0]                     r_rd_data;
    logic                           r_rd_hit;
    logic [sled_pkg::TBL_AW-1:0]    r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_hit  <= r_vld[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : 8'(r_rd_addr);

endmodule

// File: src/string_literal_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String literal escape decoder
// Decodes a quoted string body character by character into result bytes.
// ----------------------------------------------------------------------------
// Accepts one input item per cycle while the input stage is free. Each item
// is registered together with its translation table read and decoded in the
// following cycle. Its results (zero to three) are loaded into a three-slot
// result register once that has drained or as its last result is popped; it
// drains one result per cycle while the output is ready. The table comes out
// of reset as identity through per-entry valid bits, so no clearing pass is
// needed. The user writes configuration through the APB port at address 0
// (digit_radix) only while the decoder is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "string_literal_escape_decoder_defines.svh"

module string_literal_escape_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sled_pkg::APB_AW-1:0]   paddr,
    input  logic [sled_pkg::APB_DW-1:0]   pwdata,
    output logic [sled_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    sled_in_if.sink                       i_in,
    sled_out_if.source                    o_out
);

    typedef enum logic [2:0] {
        PH_PLAIN  = 3'd0,
        PH_ESC    = 3'd1,
        PH_NUM1   = 3'd2,
        PH_NUM2   = 3'd3,
        PH_AFTER3 = 3'd4
    } t_phase;

    logic [3:0]                   r_radix;
    t_phase                       r_phase;
    t_phase                       n_phase;
    logic [9:0]                   r_acc;
    logic [9:0]                   n_acc;
    logic                         r_s1_vld;
    logic                         r_s1_req_type;
    logic [7:0]                   r_s1_char;
    logic                         r_s1_eot;
    sled_pkg::t_res               r_grp [sled_pkg::MAX_RES];
    sled_pkg::t_res               n_res [sled_pkg::MAX_RES];
    logic [sled_pkg::CNT_W-1:0]   r_gcnt;
    logic [sled_pkg::CNT_W-1:0]   n_cnt;
    sled_pkg::t_tbl_req           w_tbl_req;
    logic [7:0]                   w_tdata;
    logic                         w_in_acc;
    logic                         w_pop;
    logic                         w_take;
    logic                         w_cfg_wr;

    // Configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == sled_pkg::REG_IDX_RADIX);
    assign prdata   = (paddr[2] == sled_pkg::REG_IDX_RADIX) ?
                      sled_pkg::APB_DW'(r_radix) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= sled_pkg::RADIX_RESET;
        end else if (w_cfg_wr) begin
            r_radix <= pwdata[3:0];
        end
    end

    // Handshakes
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_pop      = o_out.valid && o_out.ready;
    assign w_take     = r_s1_vld && ((r_gcnt == '0) || ((r_gcnt == 2'd1) && o_out.ready));
    assign i_in.ready = !r_s1_vld || w_take;

    assign w_tbl_req.wr_en   = w_in_acc && i_in.req_type;
    assign w_tbl_req.wr_addr = i_in.table_index;
    assign w_tbl_req.wr_data = i_in.table_value;
    assign w_tbl_req.rd_en   = w_in_acc;
    assign w_tbl_req.rd_addr = i_in.char_byte;

    sled_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_tbl_req),
        .o_rd_data (w_tdata)
    );

    // Decode
    always_comb begin
        logic [7:0]                 c;
        logic [3:0]                 dig;
        logic                       is_dig;
        logic                       cont;
        logic                       oct;
        logic                       c89;
        logic [13:0]                prod;
        logic [9:0]                 acc_grow;
        logic [sled_pkg::CNT_W-1:0] idx;
        logic                       do_plain;

        c        = r_s1_char;
        dig      = c[3:0];
        is_dig   = (c >= sled_pkg::CH_ZERO) && (c <= sled_pkg::CH_NINE);
        cont     = is_dig && (dig < r_radix);
        oct      = (r_radix == sled_pkg::RADIX_OCT);
        c89      = (c == sled_pkg::CH_EIGHT) || (c == sled_pkg::CH_NINE);
        prod     = r_acc * r_radix;
        acc_grow = prod[9:0] + 10'(dig);
        idx      = '0;
        do_plain = 1'b0;
        n_phase  = r_phase;
        n_acc    = r_acc;
        for (int k = 0; k < sled_pkg::MAX_RES; k++) begin
            n_res[k] = '{kind: sled_pkg::KIND_DATA, data: 8'h00};
        end

        if (r_s1_req_type) begin
            n_phase = r_phase;
        end else if (r_s1_eot) begin
            if ((r_phase == PH_NUM1) || (r_phase == PH_NUM2)) begin
                n_res[idx] = '{kind: sled_pkg::KIND_DATA, data: r_acc[7:0]};
                idx        = idx + 2'd1;
            end
            n_res[idx] = '{kind: sled_pkg::KIND_UNTERM, data: 8'h00};
            idx        = idx + 2'd1;
            n_phase    = PH_PLAIN;
            n_acc      = '0;
        end else begin
            case (r_phase)
                PH_ESC: begin
                    n_phase = PH_PLAIN;
                    if (c == sled_pkg::CH_N) begin
                        n_res[idx] = '{kind: sled_pkg::KIND_DATA, data: sled_pkg::CODE_LF};
                        idx        = idx + 2'd1;
                    end else if (c == sled_pkg::CH_T) begin
                        n_res[idx] = '{kind: sled_pkg::KIND_DATA, data: sled_pkg::CODE_TAB};
                        idx        = idx + 2'd1;
                    end else if (c == sled_pkg::CH_R) begin
                        n_res[idx] = '{kind: sled_pkg::KIND_DATA, data: sled_pkg::CODE_CR};
                        idx        = idx + 2'd1;
                    end else if (c == sled_pkg::CH_QUOTE) begin
                        n_res[idx] = '{kind: sled_pkg::KIND_DATA,
                                       data: sled_pkg::CODE_QUOTE};
                        idx        = idx + 2'd1;
                    end else if (is_dig) begin
                        if (oct && (c > sled_pkg::CH_SEVEN)) begin
                            n_res[idx] = '{kind: sled_pkg::KIND_NONOCT, data: 8'h00};
                            idx        = idx + 2'd1;
                        end
                        n_acc   = 10'(dig);
                        n_phase = PH_NUM1;
                    end else begin
                        n_res[idx] = '{kind: sled_pkg::KIND_DATA, data: c};
                        idx        = idx + 2'd1;
                    end
                end
                PH_NUM1, PH_NUM2: begin
                    if (cont && (r_phase == PH_NUM1)) begin
                        n_acc   = acc_grow;
                        n_phase = PH_NUM2;
                    end else if (cont) begin
                        n_res[idx] = '{kind: sled_pkg::KIND_DATA, data: acc_grow[7:0]};
                        idx        = idx + 2'd1;
                        n_acc      = '0;
                        n_phase    = PH_AFTER3;
                    end else begin
                        n_res[idx] = '{kind: sled_pkg::KIND_DATA, data: r_acc[7:0]};
                        idx        = idx + 2'd1;
                        if (oct && c89) begin
                            n_res[idx] = '{kind: sled_pkg::KIND_OCTEND, data: 8'h00};
                            idx        = idx + 2'd1;
                        end
                        n_acc    = '0;
                        do_plain = 1'b1;
                    end
                end
                PH_AFTER3: begin
                    if (oct && c89) begin
                        n_res[idx] = '{kind: sled_pkg::KIND_OCTEND, data: 8'h00};
                        idx        = idx + 2'd1;
                    end
                    do_plain = 1'b1;
                end
                default: begin
                    do_plain = 1'b1;
                end
            endcase

            if (do_plain) begin
                n_phase = PH_PLAIN;
                if (c == sled_pkg::CH_QUOTE) begin
                    n_res[idx] = '{kind: sled_pkg::KIND_CLOSED, data: 8'h00};
                    idx        = idx + 2'd1;
                end else if (c == sled_pkg::CH_BSL) begin
                    n_phase = PH_ESC;
                end else begin
                    n_res[idx] = '{kind: sled_pkg::KIND_DATA, data: w_tdata};
                    idx        = idx + 2'd1;
                end
            end
        end

        n_cnt = idx;
    end

    // Input stage, decode state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_phase  <= PH_PLAIN;
            r_acc    <= '0;
            r_gcnt   <= '0;
        end else begin
            if (w_in_acc) begin
                r_s1_vld      <= 1'b1;
                r_s1_req_type <= i_in.req_type;
                r_s1_char     <= i_in.char_byte;
                r_s1_eot      <= i_in.end_of_text;
            end else if (w_take) begin
                r_s1_vld <= 1'b0;
            end

            if (w_take) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_gcnt  <= n_cnt;
                r_grp   <= n_res;
            end else if (w_pop) begin
                r_gcnt   <= r_gcnt - 2'd1;
                r_grp[0] <= r_grp[1];
                r_grp[1] <= r_grp[2];
            end
        end
    end

    assign o_out.valid       = (r_gcnt != '0);
    assign o_out.result_kind = r_grp[0].kind;
    assign o_out.out_byte    = r_grp[0].data;
    assign o_out.last_of_run = (r_gcnt == 2'd1);

    `SLED_ASSERT(a_take_loads_count, w_take |=> (r_gcnt == $past(n_cnt)), "result count not loaded")
    `SLED_ASSERT(a_table_write_silent, (w_take && r_s1_req_type) |=> (r_gcnt == '0), "table write produced results")
    `SLED_ASSERT(a_eot_clears, (w_take && !r_s1_req_type && r_s1_eot) |=> ((r_phase == PH_PLAIN) && (r_acc == '0)), "end of text left decode state")
    `SLED_ASSERT(a_warn_zero_byte, (o_out.valid && (o_out.result_kind != sled_pkg::KIND_DATA)) |-> (o_out.out_byte == 8'h00), "warning carries nonzero byte")
    `SLED_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!o_out.valid && !r_s1_vld), "results pending after reset")

endmodule
